[rtl/core/hmq_pkg.sv]
// Package for the binary min-heap queue: sizes, status and operation codes,
// item structs and the control enum. No dependencies; the top level and the compare cell import it.
`default_nettype none

package hmq_pkg;

  // Heap size and field widths.
  localparam int DEPTH  = 64;
  localparam int KEY_W  = 16;
  localparam int DATA_W = 32;

  // Count width, number of heap levels and derived index widths.
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int NLEV   = $clog2(DEPTH + 1);
  localparam int LEV_W  = (NLEV > 1) ? $clog2(NLEV) : 1;
  localparam int SLOT_W = NLEV - 1;
  localparam int POS_W  = NLEV + 1;

  // Operation codes.
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic                     func;
    logic signed [KEY_W-1:0]  priority_req;
    logic        [DATA_W-1:0] item_data;
  } hmq_in_t;

  typedef struct packed {
    logic        [1:0]        status;
    logic signed [KEY_W-1:0]  removed_priority;
    logic        [DATA_W-1:0] removed_data;
    logic        [CNT_W-1:0]  entry_total;
    logic                     queue_empty;
    logic        [DATA_W-1:0] head_data;
  } hmq_out_t;

  // One heap entry.
  typedef struct packed {
    logic signed [KEY_W-1:0]  key;
    logic        [DATA_W-1:0] data;
  } hmq_entry_t;

  // Decision of one level cell: move the entry, which child, what moves.
  typedef struct packed {
    logic       move;
    logic       side;
    hmq_entry_t pick;
  } hmq_dec_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_UP,
    S_DOWN,
    S_REPLY
  } hmq_state_t;

  // Level of a heap position, given the position plus one.
  function automatic logic [LEV_W-1:0] pos_lev(input logic [CNT_W-1:0] p1);
    logic [LEV_W-1:0] lev;
    lev = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (p1[i]) lev = LEV_W'(i);
    end
    return lev;
  endfunction

  // Slot within its level of a heap position, given the position plus one.
  function automatic logic [SLOT_W-1:0] pos_slot(input logic [CNT_W-1:0] p1);
    logic [CNT_W-1:0] msk;
    msk = CNT_W'(1) << pos_lev(p1);
    return SLOT_W'(p1 & ~msk);
  endfunction

endpackage

`default_nettype wire

[rtl/core/binary_min_heap_queue_unit.sv]
// Top level of the binary min-heap priority queue: level memories, a row
// of level compare cells and the sift controller. Depends on hmq_pkg,
// hmq_ram and hmq_cell.
//
// One item is taken at a time: start is accepted while busy is low, and
// exactly one result follows, shown for one cycle with out_valid high; the
// receiver cannot stall it and must take it then. The heap is kept one
// level per cell, the root in a register and each lower level in its own
// memory pair with registered reads, and the moving entry steps one level
// per cycle, so the depth of the sift sets the time. An insert climbs level
// by level in the up state and then replies; a remove first loads the last
// entry to the root, sinks level by level in the down state and then
// replies. Full and empty cases, an insert into an empty queue and a remove
// of the last entry go straight to the reply. The next item can be taken in
// the cycle after the result. Priorities compare as signed values; on equal
// children the right one is taken. Memory contents need no clearing after
// reset.
`default_nettype none

module binary_min_heap_queue_unit
  import hmq_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire hmq_in_t in_item,
  output logic         out_valid,
  output hmq_out_t     out_item
);

  hmq_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  hmq_entry_t       tok_r, tok_nxt;
  logic [LEV_W-1:0] lev_r, lev_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  hmq_entry_t       root_r;
  logic [1:0]       status_r, status_nxt;
  hmq_entry_t       rem_r, rem_nxt;

  // Memory access controls.
  logic             rd_en;
  logic [LEV_W-1:0] rd_lev;
  logic [SLOT_W-1:0] rd_slot;
  logic             wr_en;
  logic [LEV_W-1:0] wr_lev;
  logic [SLOT_W-1:0] wr_slot;
  hmq_entry_t       wr_ent;

  hmq_entry_t lvl_l [NLEV];
  hmq_entry_t lvl_r [NLEV];
  hmq_dec_t   dec   [NLEV];

  logic              is_down;
  logic [LEV_W-1:0]  up_idx, dn_idx;
  hmq_dec_t          up_dec, dn_dec;
  logic [POS_W-1:0]  lpos;
  logic              lft_ok, rgt_ok;
  logic [SLOT_W-1:0] child_slot;
  logic              up_go, dn_go;
  logic              full, empty;
  logic [CNT_W-1:0]  ins_p1;
  logic [LEV_W-1:0]  ins_lev, last_lev;
  logic [SLOT_W-1:0] ins_slot, last_slot;
  hmq_entry_t        in_ent, ld_ent;

  // Level 0 is the root register itself.
  assign lvl_l[0] = root_r;
  assign lvl_r[0] = root_r;

  // One memory pair per lower level; slot s lives at address s/2, side s[0].
  for (genvar k = 1; k < NLEV; k++) begin : g_lvl
    localparam int WORDS = 1 << (k - 1);
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    logic [SLOT_W-1:0] wa, ra;
    logic              sel_w, sel_r;

    assign wa    = wr_slot >> 1;
    assign ra    = rd_slot >> 1;
    assign sel_w = wr_en && (wr_lev == LEV_W'(k));
    assign sel_r = rd_en && (rd_lev == LEV_W'(k));

    hmq_ram #(.WORDS(WORDS), .WIDTH($bits(hmq_entry_t))) u_left (
      .clk   (clk),
      .we    (sel_w && !wr_slot[0]),
      .waddr (wa[AW-1:0]),
      .wdata (wr_ent),
      .re    (sel_r),
      .raddr (ra[AW-1:0]),
      .rdata (lvl_l[k])
    );

    hmq_ram #(.WORDS(WORDS), .WIDTH($bits(hmq_entry_t))) u_right (
      .clk   (clk),
      .we    (sel_w && wr_slot[0]),
      .waddr (wa[AW-1:0]),
      .wdata (wr_ent),
      .re    (sel_r),
      .raddr (ra[AW-1:0]),
      .rdata (lvl_r[k])
    );
  end

  // Row of level cells, each judging the moving entry against its level.
  assign is_down = (state_r == S_DOWN);

  for (genvar k = 0; k < NLEV; k++) begin : g_cell
    hmq_cell u_cell (
      .down     (is_down),
      .tok_key  (tok_r.key),
      .left     (lvl_l[k]),
      .right    (lvl_r[k]),
      .rgt_ok   (rgt_ok),
      .par_side (slot_r[SLOT_W > 1 ? 1 : 0] & (SLOT_W > 1)),
      .dec      (dec[k])
    );
  end

  // Pick the cell above when climbing and the cell below when sinking.
  assign up_idx = (lev_r == '0) ? '0 : lev_r - 1'b1;
  assign dn_idx = (lev_r == LEV_W'(NLEV - 1)) ? lev_r : lev_r + 1'b1;
  assign up_dec = dec[up_idx];
  assign dn_dec = dec[dn_idx];

  // Children of the current slot and whether they are held.
  assign lpos   = ((POS_W'(1) << (lev_r + 1'b1)) - POS_W'(1)) + POS_W'({slot_r, 1'b0});
  assign lft_ok = (lev_r != LEV_W'(NLEV - 1)) && (lpos < POS_W'(count_r));
  assign rgt_ok = lft_ok && ((lpos + POS_W'(1)) < POS_W'(count_r));
  assign child_slot = SLOT_W'({slot_r, dn_dec.side});

  assign up_go = (lev_r != '0) && up_dec.move;
  assign dn_go = lft_ok && dn_dec.move;

  // Where a new entry lands and where the last entry sits.
  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);
  assign ins_p1    = count_r + 1'b1;
  assign ins_lev   = pos_lev(ins_p1);
  assign ins_slot  = pos_slot(ins_p1);
  assign last_lev  = pos_lev(count_r);
  assign last_slot = pos_slot(count_r);
  assign in_ent    = '{key: in_item.priority_req, data: in_item.item_data};
  assign ld_ent    = slot_r[0] ? lvl_r[lev_r] : lvl_l[lev_r];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_item.func == FUNC_INSERT) begin
            state_nxt = (full || empty) ? S_REPLY : S_UP;
          end else begin
            state_nxt = (empty || (count_r == CNT_W'(1))) ? S_REPLY : S_LOAD;
          end
        end
      end
      S_LOAD:  state_nxt = S_DOWN;
      S_UP:    state_nxt = up_go ? S_UP : S_REPLY;
      S_DOWN:  state_nxt = dn_go ? S_DOWN : S_REPLY;
      S_REPLY: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory controls for each state.
  always_comb begin
    count_nxt  = count_r;
    tok_nxt    = tok_r;
    lev_nxt    = lev_r;
    slot_nxt   = slot_r;
    status_nxt = status_r;
    rem_nxt    = rem_r;
    rd_en      = 1'b0;
    rd_lev     = '0;
    rd_slot    = '0;
    wr_en      = 1'b0;
    wr_lev     = lev_r;
    wr_slot    = slot_r;
    wr_ent     = tok_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          rem_nxt = '0;
          if (in_item.func == FUNC_INSERT) begin
            if (full) begin
              status_nxt = ST_FULL;
            end else begin
              status_nxt = ST_OK;
              tok_nxt    = in_ent;
              count_nxt  = ins_p1;
              lev_nxt    = ins_lev;
              slot_nxt   = ins_slot;
              if (empty) begin
                wr_en   = 1'b1;
                wr_lev  = '0;
                wr_slot = '0;
                wr_ent  = in_ent;
              end else begin
                rd_en   = 1'b1;
                rd_lev  = ins_lev - 1'b1;
                rd_slot = ins_slot >> 1;
              end
            end
          end else begin
            if (empty) begin
              status_nxt = ST_EMPTY;
            end else begin
              status_nxt = ST_OK;
              rem_nxt    = root_r;
              count_nxt  = count_r - 1'b1;
              lev_nxt    = last_lev;
              slot_nxt   = last_slot;
              rd_en      = (count_r != CNT_W'(1));
              rd_lev     = last_lev;
              rd_slot    = last_slot;
            end
          end
        end
      end
      S_LOAD: begin
        // The last entry becomes the moving entry, starting at the root.
        tok_nxt  = ld_ent;
        lev_nxt  = '0;
        slot_nxt = '0;
        rd_en    = 1'b1;
        rd_lev   = LEV_W'(1);
        rd_slot  = '0;
      end
      S_UP: begin
        wr_en = 1'b1;
        if (up_go) begin
          // The parent moves down into the current slot.
          wr_ent   = up_dec.pick;
          lev_nxt  = lev_r - 1'b1;
          slot_nxt = slot_r >> 1;
          rd_en    = (lev_r >= LEV_W'(2));
          rd_lev   = lev_r - LEV_W'(2);
          rd_slot  = slot_r >> 2;
        end
      end
      S_DOWN: begin
        wr_en = 1'b1;
        if (dn_go) begin
          // The chosen child moves up into the current slot.
          wr_ent   = dn_dec.pick;
          lev_nxt  = lev_r + 1'b1;
          slot_nxt = child_slot;
          rd_en    = (lev_r < LEV_W'(NLEV - 2));
          rd_lev   = lev_r + LEV_W'(2);
          rd_slot  = SLOT_W'({child_slot, 1'b0});
        end
      end
      S_REPLY: begin
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Payload registers; the root copy follows every write to level 0.
  always_ff @(posedge clk) begin
    tok_r    <= tok_nxt;
    lev_r    <= lev_nxt;
    slot_r   <= slot_nxt;
    status_r <= status_nxt;
    rem_r    <= rem_nxt;
    if (wr_en && (wr_lev == '0)) begin
      root_r <= wr_ent;
    end
  end

  // Handshake and result fields.
  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_REPLY);

  always_comb begin
    out_item.status           = status_r;
    out_item.removed_priority = rem_r.key;
    out_item.removed_data     = rem_r.data;
    out_item.entry_total      = count_r;
    out_item.queue_empty      = (count_r == '0);
    out_item.head_data        = (count_r == '0) ? '0 : root_r.data;
  end

endmodule

`default_nettype wire

[rtl/core/hmq_ram.sv]
// Generic single-write, single-read memory with registered read data.
// Holds the entries of one heap level half; no dependencies.
`default_nettype none

module hmq_ram #(
  parameter int WORDS = 2,
  parameter int WIDTH = 8,
  parameter int AW    = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [WORDS];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/hmq_cell.sv]
// Compare cell of one heap level: decides a sift step against the pair
// of entries read from its level. Depends on hmq_pkg.
`default_nettype none

module hmq_cell
  import hmq_pkg::*;
(
  input  wire logic       down,
  input  wire logic [KEY_W-1:0] tok_key,
  input  wire hmq_entry_t left,
  input  wire hmq_entry_t right,
  input  wire logic       rgt_ok,
  input  wire logic       par_side,
  output hmq_dec_t        dec
);

  logic signed [KEY_W-1:0] tk;
  hmq_entry_t              child;
  logic                    child_side;
  hmq_entry_t              parent;

  assign tk = $signed(tok_key);

  // Sifting down takes the smaller child; a tie goes to the right one.
  always_comb begin
    if (rgt_ok && !($signed(left.key) < $signed(right.key))) begin
      child      = right;
      child_side = 1'b1;
    end else begin
      child      = left;
      child_side = 1'b0;
    end
  end

  // Sifting up compares against the parent, which sits on one side of the pair.
  assign parent = par_side ? right : left;

  always_comb begin
    if (down) begin
      dec.move = tk > $signed(child.key);
      dec.side = child_side;
      dec.pick = child;
    end else begin
      dec.move = tk < $signed(parent.key);
      dec.side = par_side;
      dec.pick = parent;
    end
  end

endmodule

`default_nettype wire
